// File: design/nfa_pkg.sv
`timescale 1ns / 1ps

package nfa_pkg;

    // Item op codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_MARK  = 3'd1;
    localparam logic [2:0] OP_SYM   = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // Result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    localparam int unsigned MASK_W = 32;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] from_state;
        logic [4:0] to_state;
        logic [7:0] symbol;
        logic       mark_start;
        logic       mark_accept;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic              accepted;
        logic [MASK_W-1:0] reached_mask;
        logic [MASK_W-1:0] accepting_mask;
    } t_out_item;

    typedef struct packed {
        logic [4:0] src;
        logic [7:0] sym;
        logic [4:0] dst;
    } t_arc;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

endpackage

// File: design/nfa_arc_mem.sv
`timescale 1ns / 1ps

module nfa_arc_mem
    import nfa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_arc          i_wr_arc,
    input  logic [AW-1:0] i_rd_addr,
    output t_arc          o_rd_arc
);

    t_arc r_mem [DEPTH];
    t_arc r_rd_arc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_arc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_arc <= r_mem[i_rd_addr];
    end

    assign o_rd_arc = r_rd_arc;

endmodule

// File: design/nfa_symbol_matcher.sv
// Channel | Direction | Handshake                    | Payload
// in      | input     | i_in_valid / o_in_stall      | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_stall    | o_out_item (t_out_item)
//
// Add, mark, end-of-string and clear items are handled in the idle state.
// A symbol item with arcs stored moves to a scan state that stalls the input until
//   every stored arc has been compared (an empty table clears the active set instead): the single read
//   port of the transition memory delivers one stored arc per cycle to the compare unit.
// A result that meets a stalled, occupied output register waits in a holding
//   register; the input stalls until it moves on.
// Reset clears the count, marks, active set and control; arc storage is left as is.
`timescale 1ns / 1ps

module nfa_symbol_matcher
    import nfa_pkg::*;
#(
    parameter int NUM_STATES      = 32,
    parameter int NUM_TRANSITIONS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (NUM_TRANSITIONS > 1) ? $clog2(NUM_TRANSITIONS) : 1;
    localparam int CW = $clog2(NUM_TRANSITIONS + 1);
    localparam logic [CW-1:0] CountFull = CW'(NUM_TRANSITIONS);
    localparam logic [MASK_W-1:0] StateMask = (NUM_STATES >= MASK_W) ? {MASK_W{1'b1}}
                                              : MASK_W'((64'd1 << NUM_STATES) - 64'd1);

    t_state            r_state,  n_state;
    logic [CW-1:0]     r_count,  n_count;
    logic [MASK_W-1:0] r_start,  n_start;
    logic [MASK_W-1:0] r_accept, n_accept;
    logic [MASK_W-1:0] r_active, n_active;
    logic              r_fresh,  n_fresh;
    logic [MASK_W-1:0] r_cur,    n_cur;
    logic [MASK_W-1:0] r_next,   n_next;
    logic [7:0]        r_sym,    n_sym;
    logic [CW-1:0]     r_issue,  n_issue;
    logic              r_chk,    n_chk;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,    n_out;
    t_out_item         r_pend,   n_pend;

    logic              in_acc;
    logic              out_free;
    logic              mem_we;
    logic [AW-1:0]     rd_addr;
    t_arc              wr_arc;
    t_arc              rd_arc;
    logic [MASK_W-1:0] reached;
    logic [MASK_W-1:0] src_bit;
    logic [MASK_W-1:0] dst_bit;
    logic              full;
    t_out_item         res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign full     = (r_count == CountFull);
    assign reached  = r_fresh ? r_start : r_active;
    assign src_bit  = (MASK_W'(1) << i_in_item.from_state) & StateMask;
    assign dst_bit  = (MASK_W'(1) << rd_arc.dst) & StateMask;
    assign wr_arc   = '{src: i_in_item.from_state, sym: i_in_item.symbol,
                        dst: i_in_item.to_state};
    assign mem_we   = in_acc && (i_in_item.op == OP_ADD) && !full;

    nfa_arc_mem #(
        .DEPTH (NUM_TRANSITIONS),
        .AW    (AW)
    ) u_arc_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_arc  (wr_arc),
        .i_rd_addr (rd_addr),
        .o_rd_arc  (rd_arc)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_start     = r_start;
        n_accept    = r_accept;
        n_active    = r_active;
        n_fresh     = r_fresh;
        n_cur       = r_cur;
        n_next      = r_next;
        n_sym       = r_sym;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_pend      = r_pend;
        rd_addr     = r_issue[AW-1:0];
        res         = '0;
        o_in_stall  = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.op)
                        OP_ADD: begin
                            if (full) begin
                                res.kind = KIND_DROP;
                                if (out_free) begin
                                    n_out_valid = 1'b1;
                                    n_out       = res;
                                end else begin
                                    n_pend  = res;
                                    n_state = S_HOLD;
                                end
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_MARK: begin
                            if (i_in_item.mark_start) begin
                                n_start = r_start | src_bit;
                            end
                            if (i_in_item.mark_accept) begin
                                n_accept = r_accept | src_bit;
                            end
                        end
                        OP_SYM: begin
                            n_cur   = reached;
                            n_next  = '0;
                            n_sym   = i_in_item.symbol;
                            n_issue = '0;
                            n_fresh = 1'b0;
                            if (r_count == '0) begin
                                n_active = '0;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_END: begin
                            res.kind           = KIND_VERDICT;
                            res.reached_mask   = reached;
                            res.accepting_mask = reached & r_accept;
                            res.accepted       = |(reached & r_accept);
                            n_active = '0;
                            n_fresh  = 1'b1;
                            if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out       = res;
                            end else begin
                                n_pend  = res;
                                n_state = S_HOLD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_start  = '0;
                            n_accept = '0;
                            n_active = '0;
                            n_fresh  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle; compare the arc that comes back next cycle
                if (r_issue != r_count) begin
                    n_chk   = 1'b1;
                    n_issue = r_issue + CW'(1);
                end
                if (r_chk && (rd_arc.sym == r_sym) && r_cur[rd_arc.src]) begin
                    n_next = r_next | dst_bit;
                end
                if ((r_issue == r_count) && !r_chk) begin
                    n_active = r_next;
                    n_state  = S_IDLE;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start     <= '0;
            r_accept    <= '0;
            r_active    <= '0;
            r_fresh     <= 1'b1;
            r_issue     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_start     <= n_start;
            r_accept    <= n_accept;
            r_active    <= n_active;
            r_fresh     <= n_fresh;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_next <= n_next;
        r_sym  <= n_sym;
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountFull)
        else $error("transition count beyond table depth");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_count))
        else $error("scan read index beyond stored arcs");

    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (n_state == S_IDLE) |-> (r_issue == r_count) && !r_chk)
        else $error("scan left before every arc was compared");

    a_hold_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_valid)
        else $error("held result while output register empty");

endmodule

// File: sim/nfa_match_checker.sv
`timescale 1ns / 1ps

module nfa_match_checker
    import nfa_pkg::*;
#(
    parameter int NUM_TRANSITIONS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    t_arc        arc_store [NUM_TRANSITIONS];
    int unsigned arc_count;
    logic [31:0] start_set;
    logic [31:0] accept_set;
    logic [31:0] active_set;
    logic        fresh_string;
    t_out_item   pending_results [$];
    t_out_item   want;
    int          mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
    end

    task automatic clear_automaton();
        arc_count    = 0;
        start_set    = '0;
        accept_set   = '0;
        active_set   = '0;
        fresh_string = 1'b1;
    endtask

    // Append one expected result at the tail of the queue.
    task automatic queue_result(input t_out_item r);
        pending_results = {pending_results, r};
    endtask

    // Advance the automaton by one accepted item; queue any result it causes.
    task automatic apply_item(input t_in_item it);
        t_out_item   res;
        t_arc        arc;
        logic [31:0] cur;
        logic [31:0] nxt;
        res = '0;
        case (it.op)
            OP_ADD: begin
                if (arc_count >= NUM_TRANSITIONS) begin
                    res.kind = KIND_DROP;
                    queue_result(res);
                end else begin
                    arc.src = it.from_state;
                    arc.sym = it.symbol;
                    arc.dst = it.to_state;
                    arc_store[arc_count] = arc;
                    arc_count++;
                end
            end
            OP_MARK: begin
                if (it.mark_start)  start_set[it.from_state]  = 1'b1;
                if (it.mark_accept) accept_set[it.from_state] = 1'b1;
            end
            OP_SYM: begin
                cur = fresh_string ? start_set : active_set;
                nxt = '0;
                for (int i = 0; i < arc_count; i++) begin
                    if (arc_store[i].sym == it.symbol && cur[arc_store[i].src])
                        nxt[arc_store[i].dst] = 1'b1;
                end
                active_set   = nxt;
                fresh_string = 1'b0;
            end
            OP_END: begin
                cur = fresh_string ? start_set : active_set;
                res.kind           = KIND_VERDICT;
                res.reached_mask   = cur;
                res.accepting_mask = cur & accept_set;
                res.accepted       = |(cur & accept_set);
                queue_result(res);
                active_set   = '0;
                fresh_string = 1'b1;
            end
            OP_CLEAR: clear_automaton();
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_automaton();
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, i_out_item);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(i_out_item.kind));
                    compare_field("accepted", 32'(want.accepted),
                                  32'(i_out_item.accepted));
                    compare_field("reached_mask", want.reached_mask,
                                  i_out_item.reached_mask);
                    compare_field("accepting_mask", want.accepting_mask,
                                  i_out_item.accepting_mask);
                end
            end
            if (i_in_valid && !i_in_stall)
                apply_item(i_in_item);
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nfa_pkg::*;

    localparam int ITEM_TARGET    = 1250;
    localparam int WATCHDOG_LIMIT = 5000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_stall = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int fail_count;
    int pending;
    int items_sent = 0;
    int burst_left = 0;
    int stall_run  = 0;
    int stall_mode = 0;
    int idle_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    nfa_symbol_matcher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    nfa_match_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Output stall: switch between free-running, light and heavy stalling.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_run  <= $urandom_range(20, 200);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("FAIL nfa_symbol_matcher");
            $finish;
        end
    end

    function automatic t_in_item mk_item(input logic [2:0] op, input logic [4:0] fs,
                                         input logic [4:0] ts, input logic [7:0] sym,
                                         input logic ms, input logic ma);
        t_in_item it;
        it.op          = op;
        it.from_state  = fs;
        it.to_state    = ts;
        it.symbol      = sym;
        it.mark_start  = ms;
        it.mark_accept = ma;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        return mk_item(3'($urandom_range(5, 7)), 5'($urandom), 5'($urandom),
                       8'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Hold the item until accepted, then idle for a gap at the end of a burst.
    task automatic drive_item(input t_in_item it);
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.op <= OP_CLEAR) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Build a small automaton over a narrow state pool and alphabet, then run strings.
    task automatic run_program();
        logic [4:0] base;
        logic [7:0] alpha [4];
        int         n_arcs;
        int         n_strings;
        int         len;
        base = 5'($urandom);
        for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
        if ($urandom_range(0, 4) != 0)
            drive_item(mk_item(OP_CLEAR, 5'($urandom), 5'($urandom), 8'($urandom),
                               1'($urandom), 1'($urandom)));
        n_arcs = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72)
                                             : $urandom_range(2, 14);
        for (int i = 0; i < n_arcs; i++)
            drive_item(mk_item(OP_ADD, base + 5'($urandom_range(0, 7)),
                               base + 5'($urandom_range(0, 7)),
                               alpha[$urandom_range(0, 3)], 1'($urandom), 1'($urandom)));
        repeat ($urandom_range(1, 4))
            drive_item(mk_item(OP_MARK, base + 5'($urandom_range(0, 7)), 5'($urandom),
                               8'($urandom), 1'($urandom), 1'($urandom)));
        n_strings = $urandom_range(2, 6);
        for (int s = 0; s < n_strings; s++) begin
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 15))
                    0: drive_item(noise_item());
                    1: drive_item(mk_item(OP_SYM, 5'($urandom), 5'($urandom),
                                          8'($urandom), 1'($urandom), 1'($urandom)));
                    2: drive_item(mk_item(OP_MARK, base + 5'($urandom_range(0, 7)),
                                          5'($urandom), 8'($urandom),
                                          1'($urandom), 1'($urandom)));
                    3: if ($urandom_range(0, 7) == 0)
                           drive_item(mk_item(OP_CLEAR, 5'($urandom), 5'($urandom),
                                              8'($urandom), 1'($urandom), 1'($urandom)));
                    default: drive_item(mk_item(OP_SYM, 5'($urandom), 5'($urandom),
                                                alpha[$urandom_range(0, 3)],
                                                1'($urandom), 1'($urandom)));
                endcase
            end
            drive_item(mk_item(OP_END, 5'($urandom), 5'($urandom), 8'($urandom),
                               1'($urandom), 1'($urandom)));
        end
        if ($urandom_range(0, 3) == 0) drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // End on an empty automaton, then marks with each flag combination.
        drive_item(mk_item(OP_END,  5'd0,  5'd0,  8'h00, 1'b0, 1'b0));
        drive_item(mk_item(OP_MARK, 5'd0,  5'd31, 8'hFF, 1'b1, 1'b0));
        drive_item(mk_item(OP_MARK, 5'd31, 5'd0,  8'h00, 1'b0, 1'b1));
        drive_item(mk_item(OP_MARK, 5'd5,  5'd0,  8'h00, 1'b1, 1'b1));
        drive_item(mk_item(OP_MARK, 5'd7,  5'd31, 8'hFF, 1'b0, 1'b0));
        drive_item(mk_item(OP_ADD,  5'd0,  5'd31, 8'h00, 1'b1, 1'b1));
        drive_item(mk_item(OP_ADD,  5'd0,  5'd5,  8'hFF, 1'b0, 1'b0));
        drive_item(mk_item(OP_ADD,  5'd5,  5'd5,  8'hFF, 1'b0, 1'b0));
        drive_item(mk_item(OP_ADD,  5'd5,  5'd5,  8'hFF, 1'b1, 1'b0));
        // Empty string reports the start set.
        drive_item(mk_item(OP_END,  5'd31, 5'd31, 8'hFF, 1'b1, 1'b1));
        drive_item(mk_item(OP_SYM,  5'd0,  5'd0,  8'h00, 1'b0, 1'b0));
        drive_item(mk_item(OP_END,  5'd0,  5'd0,  8'h00, 1'b0, 1'b0));
        drive_item(mk_item(OP_SYM,  5'd0,  5'd0,  8'hFF, 1'b0, 1'b0));
        drive_item(mk_item(OP_SYM,  5'd31, 5'd31, 8'hFF, 1'b1, 1'b1));
        // Mark mid-string: start marks do not touch the active set.
        drive_item(mk_item(OP_MARK, 5'd31, 5'd0,  8'h00, 1'b1, 1'b0));
        drive_item(mk_item(OP_END,  5'd0,  5'd0,  8'h00, 1'b0, 1'b0));
        // Dead string stays dead.
        drive_item(mk_item(OP_SYM,  5'd0,  5'd0,  8'h55, 1'b0, 1'b0));
        drive_item(mk_item(OP_SYM,  5'd0,  5'd0,  8'hFF, 1'b0, 1'b0));
        drive_item(mk_item(OP_END,  5'd0,  5'd0,  8'h00, 1'b0, 1'b0));
        drive_item(mk_item(3'd5, 5'd31, 5'd31, 8'hFF, 1'b1, 1'b1));
        drive_item(mk_item(3'd6, 5'd0,  5'd0,  8'h00, 1'b0, 1'b0));
        drive_item(mk_item(3'd7, 5'd21, 5'd10, 8'hA5, 1'b1, 1'b0));
        drive_item(mk_item(OP_CLEAR, 5'd0, 5'd0, 8'h00, 1'b0, 1'b0));
        drive_item(mk_item(OP_END,   5'd0, 5'd0, 8'h00, 1'b0, 1'b0));
        drain_results();

        while (items_sent < ITEM_TARGET) run_program();

        drain_results();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS nfa_symbol_matcher");
        else
            $display("FAIL nfa_symbol_matcher");
        $finish;
    end

endmodule
